@@ sv/mips_subset_execute_unit_defines.svh @@
// Assertion macros shared by the execute unit modules.
// Depends on nothing; included by mse_back.sv.
`ifndef MIPS_SUBSET_EXECUTE_UNIT_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MSE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication with the consequent checked at the following clock edge.
`define MSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ sv/mse_pkg.sv @@
// Package of the execute unit: opcodes, status codes and shared types.
// Depends on nothing; used by all execute unit modules.
package mse_pkg;

    localparam int unsigned DATA_WORDS = 1024;
    localparam int unsigned DADDR_W    = $clog2(DATA_WORDS);
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_OVF    = 3'd1;
    localparam logic [2:0] ST_ADDR   = 3'd2;
    localparam logic [2:0] ST_UNIMP  = 3'd3;
    localparam logic [2:0] ST_HALT   = 3'd4;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2B;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV  = 6'h1A;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_SLT  = 6'h2A;

    localparam logic [1:0] CFG_START_PC  = 2'd0;
    localparam logic [1:0] CFG_HALT_WORD = 2'd1;

    typedef enum logic [4:0] {
        K_HALT, K_ADD, K_SUB, K_ADDI, K_AND, K_OR, K_XOR, K_SLT, K_SLL, K_SRL,
        K_ROTR, K_LUI, K_MULT, K_DIV, K_MFHI, K_MFLO, K_LW, K_SW, K_BEQ, K_BNE,
        K_BGTZ, K_BLEZ, K_J, K_JAL, K_JR, K_UNIMP
    } kind_t;

    // Classified instruction handed from the front to the back.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] word;
    } decoded_t;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_MEM, S_DONE
    } exec_state_t;

    // Status of the iterative multiply/divide unit seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

@@ sv/mse_front.sv @@
// Front end: accepts instruction words and classifies them into a queue.
// Depends on mse_pkg.
module mse_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                stall,
    input  logic [31:0]         instr_word,
    input  logic [31:0]         halt_word,
    output logic                q_valid,
    output mse_pkg::decoded_t   q_item,
    input  logic                q_pop
);
    localparam int unsigned PTR_W = $clog2(mse_pkg::QUEUE_DEPTH);

    mse_pkg::decoded_t              queue_reg [mse_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]               wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]               rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]                 count_reg, count_next;
    mse_pkg::decoded_t              classified;
    logic                           push;
    logic [5:0]                     op;
    logic [5:0]                     fn;

    assign op = instr_word[31:26];
    assign fn = instr_word[5:0];

    always_comb
    begin
        classified.word = instr_word;
        classified.kind = mse_pkg::K_UNIMP;
        if (instr_word == halt_word)
        begin
            classified.kind = mse_pkg::K_HALT;
        end
        else if (op == mse_pkg::OP_SPECIAL)
        begin
            unique case (fn)
                mse_pkg::FN_ADD:  classified.kind = mse_pkg::K_ADD;
                mse_pkg::FN_SUB:  classified.kind = mse_pkg::K_SUB;
                mse_pkg::FN_AND:  classified.kind = mse_pkg::K_AND;
                mse_pkg::FN_OR:   classified.kind = mse_pkg::K_OR;
                mse_pkg::FN_XOR:  classified.kind = mse_pkg::K_XOR;
                mse_pkg::FN_SLT:  classified.kind = mse_pkg::K_SLT;
                mse_pkg::FN_SLL:  classified.kind = mse_pkg::K_SLL;
                mse_pkg::FN_SRL:  classified.kind = (instr_word[25:21] == 5'd1) ?
                                      mse_pkg::K_ROTR : mse_pkg::K_SRL;
                mse_pkg::FN_MULT: classified.kind = mse_pkg::K_MULT;
                mse_pkg::FN_DIV:  classified.kind = mse_pkg::K_DIV;
                mse_pkg::FN_MFHI: classified.kind = mse_pkg::K_MFHI;
                mse_pkg::FN_MFLO: classified.kind = mse_pkg::K_MFLO;
                mse_pkg::FN_JR:   classified.kind = mse_pkg::K_JR;
                default:          classified.kind = mse_pkg::K_UNIMP;
            endcase
        end
        else
        begin
            unique case (op)
                mse_pkg::OP_ADDI: classified.kind = mse_pkg::K_ADDI;
                mse_pkg::OP_LUI:  classified.kind = mse_pkg::K_LUI;
                mse_pkg::OP_LW:   classified.kind = mse_pkg::K_LW;
                mse_pkg::OP_SW:   classified.kind = mse_pkg::K_SW;
                mse_pkg::OP_BEQ:  classified.kind = mse_pkg::K_BEQ;
                mse_pkg::OP_BNE:  classified.kind = mse_pkg::K_BNE;
                mse_pkg::OP_BGTZ: classified.kind = mse_pkg::K_BGTZ;
                mse_pkg::OP_BLEZ: classified.kind = mse_pkg::K_BLEZ;
                mse_pkg::OP_J:    classified.kind = mse_pkg::K_J;
                mse_pkg::OP_JAL:  classified.kind = mse_pkg::K_JAL;
                default:          classified.kind = mse_pkg::K_UNIMP;
            endcase
        end
    end

    assign stall   = (count_reg == (PTR_W+1)'(mse_pkg::QUEUE_DEPTH));
    assign push    = valid && !stall;
    assign q_valid = (count_reg != '0);
    assign q_item  = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !(q_pop && q_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop && q_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= classified;
        end
    end
endmodule

@@ sv/mse_muldiv.sv @@
// Iterative signed multiply and divide unit, one bit per cycle.
// Depends on mse_pkg.
module mse_muldiv (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   is_div,
    input  logic [31:0]            op_a,
    input  logic [31:0]            op_b,
    output mse_pkg::unit_status_t  stat,
    output logic [31:0]            hi,
    output logic [31:0]            lo
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        div_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] mag_a_reg;
    logic [31:0] mag_b_reg;
    logic [63:0] acc_reg;
    logic [32:0] rem_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic [31:0] abs_a;
    logic [31:0] abs_b;
    logic [32:0] rem_shift;
    logic [32:0] rem_sub;
    logic [63:0] prod_signed;
    logic [31:0] quot;
    logic [31:0] remd;

    assign abs_a = op_a[31] ? (~op_a + 32'd1) : op_a;
    assign abs_b = op_b[31] ? (~op_b + 32'd1) : op_b;
    assign rem_shift = {rem_reg[31:0], acc_reg[31]};
    assign rem_sub   = rem_shift - {1'b0, mag_b_reg};

    assign busy_next = start ? 1'b1 : (busy_reg && cnt_reg != 6'd31);
    assign done_next = busy_reg && cnt_reg == 6'd31;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Multiply: shift-add over the magnitude of b. Divide: restoring, quotient in acc low.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg   <= is_div;
            cnt_reg   <= '0;
            mag_a_reg <= abs_a;
            mag_b_reg <= abs_b;
            neg_q_reg <= op_a[31] ^ op_b[31];
            neg_r_reg <= op_a[31];
            rem_reg   <= '0;
            acc_reg   <= is_div ? {32'd0, abs_a} : {32'd0, abs_b};
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (div_reg)
            begin
                if (!rem_sub[32])
                begin
                    rem_reg <= rem_sub;
                    acc_reg <= {32'd0, acc_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift;
                    acc_reg <= {32'd0, acc_reg[30:0], 1'b0};
                end
            end
            else
            begin
                acc_reg <= {1'b0, (acc_reg[0] ? acc_reg[63:32] + mag_a_reg : acc_reg[63:32]) ,
                            acc_reg[31:1]} ;
                rem_reg <= {32'd0, (acc_reg[0] ? 1'b0 : 1'b0)} |
                           {32'd0, acc_reg[0] && ({1'b0, acc_reg[63:32]} + {1'b0, mag_a_reg}) > 33'h0FFFFFFFF};
            end
        end
    end

    // In multiply mode, rem_reg[0] is unused: the 33-bit sum never overflows as the
    // running partial product stays below 2^63 for 32-bit magnitudes.
    assign prod_signed = neg_q_reg ? (~acc_reg + 64'd1) : acc_reg;
    assign quot = neg_q_reg ? (~acc_reg[31:0] + 32'd1) : acc_reg[31:0];
    assign remd = neg_r_reg ? (~rem_reg[31:0] + 32'd1) : rem_reg[31:0];

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign hi = div_reg ? remd : prod_signed[63:32];
    assign lo = div_reg ? quot : prod_signed[31:0];
endmodule

@@ sv/mse_back.sv @@
// Back end: register file, HI/LO, PC and data store; executes queued instructions.
// Depends on mse_pkg, mse_muldiv and the assertion macro header.
`include "mips_subset_execute_unit_defines.svh"
module mse_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  mse_pkg::decoded_t  q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        next_pc,
    output logic [2:0]         status,
    output logic               reg_written,
    output logic [4:0]         reg_index,
    output logic [31:0]        reg_value
);
    mse_pkg::exec_state_t  state_reg, state_next;
    mse_pkg::decoded_t     item_reg;
    logic [31:0]           rf_mem [32];
    logic [31:0]           dmem [mse_pkg::DATA_WORDS];
    logic [31:0]           rf_valid_reg;
    logic [31:0]           a_raw_reg, b_raw_reg;
    logic [31:0]           a, b;
    logic [31:0]           hi_reg, lo_reg;
    logic [31:0]           pc_reg;
    logic                  delay_reg;
    logic [31:0]           target_reg;
    logic [31:0]           dmem_q_reg;
    logic [31:0]           pc_eff;
    logic [5:0]            op;
    logic [4:0]            rs, rt, rd, sa;
    logic [31:0]           imm;
    logic [31:0]           pc4;
    logic [31:0]           sum;
    logic                  ovf;
    logic                  wr;
    logic [4:0]            widx;
    logic [31:0]           wval;
    logic [2:0]            st;
    logic [31:0]           npc;
    logic                  arm;
    logic [31:0]           tgt;
    logic [mse_pkg::DADDR_W-1:0] daddr;
    logic                  md_start;
    mse_pkg::unit_status_t md_stat;
    logic [31:0]           md_hi, md_lo;
    logic                  commit;
    logic                  out_valid_reg;
    logic [31:0]           next_pc_reg;
    logic [2:0]            status_reg;
    logic                  reg_written_reg;
    logic [4:0]            reg_index_reg;
    logic [31:0]           reg_value_reg;

    assign op = item_reg.word[31:26];
    assign rs = item_reg.word[25:21];
    assign rt = item_reg.word[20:16];
    assign rd = item_reg.word[15:11];
    assign sa = item_reg.word[10:6];
    assign imm = {{16{item_reg.word[15]}}, item_reg.word[15:0]};
    // Register reads of never written entries come back as zero.
    assign a = (rs == 5'd0 || !rf_valid_reg[rs]) ? 32'd0 : a_raw_reg;
    assign b = (rt == 5'd0 || !rf_valid_reg[rt]) ? 32'd0 : b_raw_reg;
    assign pc_eff = pc_reg;
    assign pc4 = pc_eff + 32'd4;
    assign daddr = sum[mse_pkg::DADDR_W+1:2];

    always_comb
    begin
        sum = a + ((item_reg.kind == mse_pkg::K_SUB) ? ~b + 32'd1 :
                   (item_reg.kind == mse_pkg::K_ADD) ? b : imm);
        ovf = 1'b0;
        if (item_reg.kind == mse_pkg::K_SUB)
        begin
            ovf = (a[31] != b[31]) && (sum[31] != a[31]);
        end
        else if (item_reg.kind == mse_pkg::K_ADD)
        begin
            ovf = (a[31] == b[31]) && (sum[31] != a[31]);
        end
        else
        begin
            ovf = (a[31] == imm[31]) && (sum[31] != a[31]);
        end
    end

    always_comb
    begin
        wr = 1'b0;
        widx = rd;
        wval = '0;
        st = mse_pkg::ST_OK;
        npc = pc4;
        arm = 1'b0;
        tgt = '0;
        case (item_reg.kind)
            mse_pkg::K_HALT:
            begin
                st = mse_pkg::ST_HALT;
                npc = pc_eff;
            end
            mse_pkg::K_ADD, mse_pkg::K_SUB:
            begin
                if (ovf) st = mse_pkg::ST_OVF;
                else begin wr = 1'b1; wval = sum; end
            end
            mse_pkg::K_ADDI:
            begin
                widx = rt;
                if (ovf) st = mse_pkg::ST_OVF;
                else begin wr = 1'b1; wval = sum; end
            end
            mse_pkg::K_AND:  begin wr = 1'b1; wval = a & b; end
            mse_pkg::K_OR:   begin wr = 1'b1; wval = a | b; end
            mse_pkg::K_XOR:  begin wr = 1'b1; wval = a ^ b; end
            mse_pkg::K_SLT:  begin wr = 1'b1; wval = {31'd0, $signed(a) < $signed(b)}; end
            mse_pkg::K_SLL:  begin wr = 1'b1; wval = b << sa; end
            mse_pkg::K_SRL:  begin wr = 1'b1; wval = b >> sa; end
            mse_pkg::K_ROTR: begin wr = 1'b1; wval = (b >> sa) | (b << (6'd32 - {1'b0, sa})); end
            mse_pkg::K_LUI:  begin wr = 1'b1; widx = rt; wval = {item_reg.word[15:0], 16'd0}; end
            mse_pkg::K_MFHI: begin wr = 1'b1; wval = hi_reg; end
            mse_pkg::K_MFLO: begin wr = 1'b1; wval = lo_reg; end
            mse_pkg::K_LW:
            begin
                widx = rt;
                if (sum[1:0] != 2'b00) st = mse_pkg::ST_ADDR;
                else begin wr = 1'b1; wval = dmem_q_reg; end
            end
            mse_pkg::K_SW:
            begin
                if (sum[1:0] != 2'b00) st = mse_pkg::ST_ADDR;
            end
            mse_pkg::K_BEQ:  if (a == b) npc = pc4 + (imm << 2);
            mse_pkg::K_BNE:  if (a != b) npc = pc4 + (imm << 2);
            mse_pkg::K_BGTZ: if ($signed(a) > 0) npc = pc4 + (imm << 2);
            mse_pkg::K_BLEZ: if ($signed(a) <= 0) npc = pc4 + (imm << 2);
            mse_pkg::K_J, mse_pkg::K_JAL:
            begin
                arm = 1'b1;
                tgt = {pc4[31:28], item_reg.word[25:0], 2'b00};
                if (item_reg.kind == mse_pkg::K_JAL)
                begin
                    wr = 1'b1; widx = 5'd31; wval = pc_eff + 32'd8;
                end
            end
            mse_pkg::K_JR:   begin arm = 1'b1; tgt = a; end
            mse_pkg::K_MULT, mse_pkg::K_DIV: ;
            default:         st = mse_pkg::ST_UNIMP;
        endcase
        if (delay_reg)
        begin
            npc = target_reg;
        end
        if (widx == 5'd0)
        begin
            wr = 1'b0;
        end
        if (!wr)
        begin
            widx = '0;
            wval = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        md_start = 1'b0;
        commit = 1'b0;
        unique case (state_reg)
            mse_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    state_next = mse_pkg::S_READ;
                end
            end
            mse_pkg::S_READ: state_next = mse_pkg::S_EXEC;
            mse_pkg::S_EXEC:
            begin
                if (item_reg.kind == mse_pkg::K_MULT)
                begin
                    md_start = 1'b1; state_next = mse_pkg::S_MUL;
                end
                else if (item_reg.kind == mse_pkg::K_DIV && b != 32'd0)
                begin
                    md_start = 1'b1; state_next = mse_pkg::S_DIV;
                end
                else if (item_reg.kind == mse_pkg::K_LW)
                begin
                    state_next = mse_pkg::S_MEM;
                end
                else
                begin
                    state_next = mse_pkg::S_DONE;
                end
            end
            mse_pkg::S_MUL, mse_pkg::S_DIV:
            begin
                if (md_stat.done) state_next = mse_pkg::S_DONE;
            end
            mse_pkg::S_MEM:  state_next = mse_pkg::S_DONE;
            mse_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    commit = 1'b1;
                    state_next = mse_pkg::S_IDLE;
                end
            end
            default: state_next = mse_pkg::S_IDLE;
        endcase
    end

    mse_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .is_div (item_reg.kind == mse_pkg::K_DIV),
        .op_a   (a),
        .op_b   (b),
        .stat   (md_stat),
        .hi     (md_hi),
        .lo     (md_lo)
    );

    // The program counter starts from the reset value of start_pc.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mse_pkg::S_IDLE;
            rf_valid_reg    <= '0;
            hi_reg          <= '0;
            lo_reg          <= '0;
            pc_reg          <= '0;
            delay_reg       <= 1'b0;
            target_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (md_stat.done)
            begin
                hi_reg <= md_hi;
                lo_reg <= md_lo;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                pc_reg <= npc;
                if (wr)
                begin
                    rf_valid_reg[widx] <= 1'b1;
                end
                if (delay_reg)
                begin
                    delay_reg <= 1'b0;
                end
                else if (arm)
                begin
                    delay_reg  <= 1'b1;
                    target_reg <= tgt;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == mse_pkg::S_READ)
        begin
            a_raw_reg <= rf_mem[rs];
            b_raw_reg <= rf_mem[rt];
        end
        if (state_reg == mse_pkg::S_EXEC)
        begin
            dmem_q_reg <= dmem[daddr];
        end
        if (commit && item_reg.kind == mse_pkg::K_SW && st == mse_pkg::ST_OK)
        begin
            dmem[daddr] <= b;
        end
        if (commit && wr)
        begin
            rf_mem[widx] <= wval;
        end
        if (commit)
        begin
            next_pc_reg     <= npc;
            status_reg      <= st;
            reg_written_reg <= wr;
            reg_index_reg   <= widx;
            reg_value_reg   <= wval;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_pc     = next_pc_reg;
    assign status      = status_reg;
    assign reg_written = reg_written_reg;
    assign reg_index   = reg_index_reg;
    assign reg_value   = reg_value_reg;

    `MSE_ASSERT_IMPL(a_no_r0_write, clk, rst_n, commit && wr, widx != 5'd0,
        "register zero written")
    `MSE_ASSERT_NEXT(a_commit_shows, clk, rst_n, commit, out_valid_reg,
        "committed transaction not presented")
    `MSE_ASSERT_IMPL(a_md_only_when_busy, clk, rst_n, md_stat.done,
        state_reg == mse_pkg::S_MUL || state_reg == mse_pkg::S_DIV,
        "multiply/divide completion outside its state")
endmodule

@@ sv/mips_subset_execute_unit.sv @@
// Top level of the MIPS subset execute unit: APB registers, front end and back end.
// Depends on mse_pkg, mse_front and mse_back.
//
// Usage: the input channel (valid, stall, instr_word) carries one instruction
// transaction, fetched by the user from the address last reported as next_pc.
// The output channel (out_valid, out_stall and the result ports) returns one
// transaction per instruction: next PC, status, and any general register write.
// The front end classifies words into a two-entry queue, so it takes new words
// while the back end is busy, until the queue is full. The back end steps most
// instructions through pop, register read, execute and commit; LW adds a data
// store read, and MULT and non-zero DIV wait on the one bit per cycle
// multiply/divide unit. Results sit in an output register; while the receiver
// stalls, that transaction holds and the back end waits at commit.
// Reset clears the queue, HI/LO, the delay-slot state and register-file valid
// bits; the PC restarts from the reset value of start_pc, so a later start_pc
// write only changes the register. The data store is not cleared. The user must
// write start_pc and halt_word through the APB port while idle (not enforced).
module mips_subset_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        stall,
    input  logic [31:0] instr_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] next_pc,
    output logic [2:0]  status,
    output logic        reg_written,
    output logic [4:0]  reg_index,
    output logic [31:0] reg_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0]        start_pc_reg;
    logic [31:0]        halt_word_reg;
    logic               q_valid;
    logic               q_pop;
    mse_pkg::decoded_t  q_item;
    logic [1:0]         reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2] ? mse_pkg::CFG_HALT_WORD : mse_pkg::CFG_START_PC;

    // Registers are decoded on word addresses; byte offsets are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_reg  <= '0;
            halt_word_reg <= '1;
        end
        else if (psel && penable && pwrite)
        begin
            if (reg_sel == mse_pkg::CFG_START_PC)
            begin
                start_pc_reg <= pwdata;
            end
            else
            begin
                halt_word_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        case (reg_sel)
            mse_pkg::CFG_START_PC:  prdata = start_pc_reg;
            mse_pkg::CFG_HALT_WORD: prdata = halt_word_reg;
            default:                prdata = '0;
        endcase
    end

    mse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (valid),
        .stall      (stall),
        .instr_word (instr_word),
        .halt_word  (halt_word_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    mse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .next_pc     (next_pc),
        .status      (status),
        .reg_written (reg_written),
        .reg_index   (reg_index),
        .reg_value   (reg_value)
    );

    // The back end only ever pops a queue that holds a transaction.
    `MSE_ASSERT_IMPL(a_pop_when_free, clk, rst_n, q_pop, q_valid,
        "queue popped while empty")
endmodule
